### rtl/ercc_pkg.sv
// Shared types, constants and codes for the encoder to relative CC block.
// No dependencies; every other file imports this package.
package ercc_pkg;

  localparam int NumEncoders = 4;
  localparam int EncIdxW     = 2;
  localparam int CountW      = 32;
  localparam int ResW        = 7;   // signed residual, magnitude below the divider
  localparam int RemW        = 6;   // unsigned remainder, at most MaxDiv - 1
  localparam int DivW        = 7;
  localparam int MaxDiv      = 64;
  localparam int ChunkMax    = 63;
  localparam int ChunkW      = 6;
  localparam int MaxMessages = 16;
  localparam int StepLimit   = ChunkMax * MaxMessages;
  localparam int StepW       = 10;
  localparam int CcW         = 7;
  localparam int RelW        = 7;
  localparam int ChanW       = 5;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 7;
  localparam int DivIters    = CountW / 2;  // two quotient bits a cycle
  localparam int DivCntW     = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCountsPerStep = 3'd0,
    CfgMidiChannel   = 3'd1,
    CfgCcA           = 3'd2,
    CfgCcB           = 3'd3,
    CfgCcC           = 3'd4,
    CfgCcD           = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StPrep,
    StDiv,
    StFinish,
    StEmit
  } state_e;

  typedef logic [NumEncoders-1:0][CcW-1:0] cc_bank_t;

  typedef struct packed {
    logic [DivW-1:0]  step_div;
    logic [ChanW-1:0] midi_channel;
    cc_bank_t         cc;
  } cfg_t;

  localparam logic [DivW-1:0]  CpsReset  = 7'd4;
  localparam logic [ChanW-1:0] ChanReset = 5'd1;
  localparam cc_bank_t         CcReset   = {7'd13, 7'd12, 7'd11, 7'd10};

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the input beat
    logic check;     // compare with the previous reading, form the sum
    logic prep;      // take the magnitude, load the divider
    logic div_step;  // one radix-4 divide step
    logic finish;    // store residual, saturate step count
    logic pop;       // output beat taken
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic same_count;
    logic quot_zero;
    logic last_chunk;
  } dp_stat_t;

endpackage

### rtl/encoder_to_relative_cc_top.sv
// Top level of the encoder to relative CC block: configuration registers,
// controller and datapath. Depends on ercc_pkg, ercc_cfg, ercc_ctrl, ercc_dpath.
//
// Takes absolute quadrature count readings for four encoders and turns them
// into relative MIDI control-change messages in two's complement style.
// Each reading is compared with that encoder's previous one; the wrapping
// 32-bit difference is added to a signed per-encoder residual and divided by
// the step divider register (0 behaves as 1, anything above 64 as 64),
// truncating towards zero, with the signed remainder kept as the new
// residual. The step count saturates at +/-1008 and leaves as up to 16
// output beats of at most 63 steps each: forward steps n as n, backward as
// 128 - n, with last_message set on the final beat of the reading. An
// unchanged reading or sub-step motion yields no output beat.
// Timing: one input beat is worked at a time. A reading is captured,
// compared and prepared, then passes through the radix-4 divider (two
// quotient bits a cycle over 32 bits) and is wrapped up before the first
// output beat; after that one output beat leaves per cycle when the sink
// does not stall. An unchanged reading is dropped after the compare.
// in_stall_o is high from the beat being taken until its last output beat
// leaves or the reading is dropped; configuration writes are taken at any
// time but belong in idle periods. Reset is asynchronous and active low and
// clears counts, residuals and registers to their defaults.
module encoder_to_relative_cc_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [ercc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ercc_pkg::CfgDataW-1:0]       cfg_wdata_i,
  // reading channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ercc_pkg::EncIdxW-1:0]        encoder_index_i,
  input  logic signed [ercc_pkg::CountW-1:0]  raw_count_i,
  // message channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ercc_pkg::CcW-1:0]            controller_number_o,
  output logic [ercc_pkg::RelW-1:0]           relative_value_o,
  output logic [ercc_pkg::ChanW-1:0]          channel_out_o,
  output logic                                last_message_o
);
  import ercc_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ercc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // sequencing: one reading in flight, messages drained before next beat
  ercc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // payload held in datapath registers, stable while the sink stalls
  ercc_dpath u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_i               (cfg),
    .encoder_index_i     (encoder_index_i),
    .raw_count_i         (raw_count_i),
    .controller_number_o (controller_number_o),
    .relative_value_o    (relative_value_o),
    .channel_out_o       (channel_out_o),
    .last_message_o      (last_message_o)
  );

endmodule

### rtl/ercc_cfg.sv
// Configuration register file of the encoder to relative CC block.
// Depends on ercc_pkg.
module ercc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ercc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ercc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output ercc_pkg::cfg_t                cfg_o
);
  import ercc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgCountsPerStep: cfg_d.step_div     = cfg_wdata_i;
        CfgMidiChannel:   cfg_d.midi_channel = cfg_wdata_i[ChanW-1:0];
        CfgCcA:           cfg_d.cc[0]        = cfg_wdata_i;
        CfgCcB:           cfg_d.cc[1]        = cfg_wdata_i;
        CfgCcC:           cfg_d.cc[2]        = cfg_wdata_i;
        CfgCcD:           cfg_d.cc[3]        = cfg_wdata_i;
        default:          cfg_d = cfg_q;  // unused index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_div     <= CpsReset;
      cfg_q.midi_channel <= ChanReset;
      cfg_q.cc           <= CcReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/ercc_dpath.sv
// Datapath: per-encoder count and residual store, radix-4 restoring divider
// and chunked message formation. Depends on ercc_pkg.
module ercc_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ercc_pkg::ctrl_cmd_t            cmd_i,
  output ercc_pkg::dp_stat_t             stat_o,
  input  ercc_pkg::cfg_t                 cfg_i,
  input  logic [ercc_pkg::EncIdxW-1:0]   encoder_index_i,
  input  logic signed [ercc_pkg::CountW-1:0] raw_count_i,
  output logic [ercc_pkg::CcW-1:0]       controller_number_o,
  output logic [ercc_pkg::RelW-1:0]      relative_value_o,
  output logic [ercc_pkg::ChanW-1:0]     channel_out_o,
  output logic                           last_message_o
);
  import ercc_pkg::*;

  logic [EncIdxW-1:0]  idx_q;
  logic [CountW-1:0]   raw_q;
  logic [CountW-1:0]   prev_q [NumEncoders];
  logic [ResW-1:0]     res_q  [NumEncoders];
  logic [CountW:0]     accum_q, accum_d;
  logic                neg_q;
  logic [DivW-1:0]     div_q, div_d;
  logic [CountW-1:0]   dq_q;     // dividend in, quotient out
  logic [RemW-1:0]     rem_q;
  logic [StepW-1:0]    steps_q, steps_d;

  logic [CountW-1:0]   prev_cur, diff, mag;
  logic [ResW-1:0]     res_cur, res_d;
  logic [CountW:0]     accum_neg;
  logic [DivW-1:0]     t1, t2, r1, r2;
  logic                ge1, ge2;
  logic [ChunkW-1:0]   chunk;
  logic [RelW-1:0]     chunk_ext;

  assign prev_cur = prev_q[idx_q];
  assign res_cur  = res_q[idx_q];
  assign diff     = raw_q - prev_cur;
  assign accum_d  = {{(CountW+1-ResW){res_cur[ResW-1]}}, res_cur} + {diff[CountW-1], diff};

  // |sum| is below 2^31 + 64, so 32 bits hold it
  assign accum_neg = (CountW+1)'(~accum_q + 1'b1);
  assign mag       = accum_q[CountW] ? accum_neg[CountW-1:0] : accum_q[CountW-1:0];

  always_comb begin
    if (cfg_i.step_div == '0) begin
      div_d = DivW'(1);
    end else if (cfg_i.step_div > DivW'(MaxDiv)) begin
      div_d = DivW'(MaxDiv);
    end else begin
      div_d = cfg_i.step_div;
    end
  end

  // two restoring steps; partial remainders stay below the divider
  assign t1  = {rem_q, dq_q[CountW-1]};
  assign ge1 = t1 >= div_q;
  assign r1  = ge1 ? t1 - div_q : t1;
  assign t2  = {r1[RemW-1:0], dq_q[CountW-2]};
  assign ge2 = t2 >= div_q;
  assign r2  = ge2 ? t2 - div_q : t2;

  assign res_d = neg_q ? ResW'(~{1'b0, rem_q} + 1'b1) : {1'b0, rem_q};

  always_comb begin
    if ((|dq_q[CountW-1:StepW]) || (dq_q[StepW-1:0] > StepW'(StepLimit))) begin
      steps_d = StepW'(StepLimit);
    end else begin
      steps_d = dq_q[StepW-1:0];
    end
  end

  assign stat_o.last_chunk = steps_q <= StepW'(ChunkMax);
  assign chunk     = stat_o.last_chunk ? steps_q[ChunkW-1:0] : ChunkW'(ChunkMax);
  assign chunk_ext = {1'b0, chunk};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumEncoders; i++) begin
        prev_q[i] <= '0;
        res_q[i]  <= '0;
      end
    end else begin
      if (cmd_i.check && !stat_o.same_count) begin
        prev_q[idx_q] <= raw_q;
      end
      if (cmd_i.finish) begin
        res_q[idx_q] <= res_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q <= encoder_index_i;
      raw_q <= raw_count_i;
    end
    if (cmd_i.check) begin
      accum_q <= accum_d;
    end
    if (cmd_i.prep) begin
      neg_q <= accum_q[CountW];
      div_q <= div_d;
      dq_q  <= mag;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dq_q  <= {dq_q[CountW-3:0], ge1, ge2};
      rem_q <= r2[RemW-1:0];
    end
    if (cmd_i.finish) begin
      steps_q <= steps_d;
    end else if (cmd_i.pop) begin
      steps_q <= steps_q - StepW'(chunk);
    end
  end

  assign stat_o.same_count = raw_q == prev_cur;
  assign stat_o.quot_zero  = dq_q == '0;

  assign controller_number_o = cfg_i.cc[idx_q];
  assign relative_value_o    = neg_q ? RelW'(~chunk_ext + 1'b1) : chunk_ext;
  assign channel_out_o       = cfg_i.midi_channel;
  assign last_message_o      = stat_o.last_chunk;

endmodule

### rtl/ercc_ctrl.sv
// Control state machine: sequences capture, divide and message output.
// Depends on ercc_pkg.
module ercc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  ercc_pkg::dp_stat_t  stat_i,
  output ercc_pkg::ctrl_cmd_t cmd_o
);
  import ercc_pkg::*;

  state_e             state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StCheck;
      end
      StCheck: begin
        state_d = stat_i.same_count ? StIdle : StPrep;
      end
      StPrep: begin
        state_d = StDiv;
        cnt_d   = '0;
      end
      StDiv: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivIters - 1)) state_d = StFinish;
      end
      StFinish: begin
        state_d = stat_i.quot_zero ? StIdle : StEmit;
      end
      StEmit: begin
        if (!out_stall_i && stat_i.last_chunk) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    in_stall_o     = 1'b1;
    out_valid_o    = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      StCheck:  cmd_o.check    = 1'b1;
      StPrep:   cmd_o.prep     = 1'b1;
      StDiv:    cmd_o.div_step = 1'b1;
      StFinish: cmd_o.finish   = 1'b1;
      StEmit: begin
        out_valid_o = 1'b1;
        cmd_o.pop   = !out_stall_i;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
